/* design/column_projection_glyph_boxer_macros.svh */
// assertion macros for the glyph boxer checker
// each expects clk and rst_n in the scope where it is used
`ifndef COLUMN_PROJECTION_GLYPH_BOXER_MACROS_SVH
`define COLUMN_PROJECTION_GLYPH_BOXER_MACROS_SVH

// same-cycle implication, held off during reset
`define CPGB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glyph boxer check failed");

// next-cycle implication, held off during reset
`define CPGB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glyph boxer check failed");

`endif

/* design/cpgb_pkg.sv */
`default_nettype none

package cpgb_pkg;

  // image geometry
  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 1024;

  // field widths
  localparam int INK_W    = 32;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 10;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 6;
  localparam int WS_W     = 6;

  // scan stops once the gap passes this many times the whitespace size
  localparam int CUTOFF_FACTOR = 10;

  localparam logic [WS_W-1:0]  WS_RESET = 6'd4;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_COLS - 1);
  localparam logic [ROW_W-1:0] TOP_RESET = '1;

  // rows at or above MAX_ROWS carry no ink
  localparam logic [INK_W-1:0] ROW_MASK =
    (MAX_ROWS >= INK_W) ? '1 : INK_W'((64'd1 << MAX_ROWS) - 64'd1);

  // vertical extent of the ink in one column
  typedef struct packed {
    logic             any;
    logic [ROW_W-1:0] lo;
    logic [ROW_W-1:0] hi;
  } ink_extent_t;

  // one glyph box
  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [WIDTH_W-1:0]  width;
    logic [ROW_W-1:0]    top;
    logic [COL_W-1:0]    left;
  } box_t;

endpackage

`default_nettype wire

/* design/column_projection_glyph_boxer.sv */
// channel  dir  handshake          payload
// in       in   in_tvalid/tready   tdata: column_ink[31:0]; tlast: end_of_image
// out      out  out_tvalid/tready  tdata: left, top, width, height
// cfg      in   cfg_wr_en          cfg_wr_data: whitespace_size[5:0]
//
// one column per cycle while the output register is empty or being taken; the column
// that closes a run passes from the item register through the run tracker into the
// output register, which raises out_tvalid.
// rst_n is synchronous: it clears the scan state, empties both item registers
// and sets the whitespace size to 4.
// a stalled output holds its box; a column still moves in while the output
// register is empty or being taken.
`default_nettype none

module column_projection_glyph_boxer
  import cpgb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [INK_W-1:0] in_tdata,   // column_ink[31:0]
  input  wire logic             in_tlast,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [31:0]           out_tdata,  // box_left[9:0], box_top[14:10],
                                            // box_width[25:15], box_height[31:26]
  input  wire logic             cfg_wr_en,
  input  wire logic [WS_W-1:0]  cfg_wr_data
);

  logic             s1_valid_r, s1_valid_nxt;
  logic [INK_W-1:0] s1_ink_r;
  logic             s1_end_r;
  logic             out_valid_r, out_valid_nxt;
  box_t             out_box_r;

  logic        step_en;
  ink_extent_t extent;
  logic        emit;
  box_t        box;

  // advance when the output register can take a result
  assign step_en   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || step_en;

  cpgb_ink_extent u_ink_extent (
    .ink    (s1_ink_r),
    .extent (extent)
  );

  cpgb_run_tracker u_run_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .step_en      (step_en),
    .extent       (extent),
    .end_of_image (s1_end_r),
    .emit         (emit),
    .box          (box)
  );

  // item register occupancy
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (step_en) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_en) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_ink_r <= in_tdata;
      s1_end_r <= in_tlast;
    end
    if (step_en && emit) begin
      out_box_r <= box;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_box_r.height, out_box_r.width, out_box_r.top, out_box_r.left};

endmodule

`default_nettype wire

/* design/cpgb_ink_extent.sv */
`default_nettype none

module cpgb_ink_extent
  import cpgb_pkg::*;
(
  input  wire logic [INK_W-1:0] ink,
  output ink_extent_t           extent
);

  logic [INK_W-1:0] masked;

  assign masked = ink & ROW_MASK;

  // lowest and highest inked row
  always_comb begin
    extent.any = |masked;
    extent.lo  = '0;
    extent.hi  = '0;
    for (int i = INK_W - 1; i >= 0; i--) begin
      if (masked[i]) begin
        extent.lo = ROW_W'(i);
      end
    end
    for (int i = 0; i < INK_W; i++) begin
      if (masked[i]) begin
        extent.hi = ROW_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

/* design/cpgb_run_tracker.sv */
`default_nettype none

module cpgb_run_tracker
  import cpgb_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [WS_W-1:0] cfg_wr_data,
  input  wire logic            step_en,
  input  wire ink_extent_t     extent,
  input  wire logic            end_of_image,
  output logic                 emit,
  output box_t                 box
);

  logic [WS_W-1:0]  ws_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             open_r, open_nxt;
  logic [COL_W-1:0] left_r, left_nxt;
  logic [COL_W-1:0] right_r, right_nxt;
  logic [ROW_W-1:0] top_r, top_nxt;
  logic [ROW_W-1:0] bottom_r, bottom_nxt;
  logic [COL_W-1:0] last_col_r, last_col_nxt;
  logic             last_valid_r, last_valid_nxt;
  logic             stopped_r, stopped_nxt;

  logic [COL_W-1:0] cutoff;
  logic [COL_W-1:0] gap;
  logic             stop_now;

  // cutoff distance and gap since the last closing column
  assign cutoff   = COL_W'(ws_r) * COL_W'(CUTOFF_FACTOR);
  assign gap      = col_r - last_col_r;
  assign stop_now = stopped_r || (last_valid_r && (gap > cutoff));

  // box of the run as it stands
  assign box.left   = left_r;
  assign box.top    = top_r;
  assign box.width  = {1'b0, right_r} - {1'b0, left_r} + WIDTH_W'(1);
  assign box.height = {1'b0, bottom_r} - {1'b0, top_r} + HEIGHT_W'(1);

  // one column of run tracking
  always_comb begin
    col_nxt        = col_r;
    open_nxt       = open_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    top_nxt        = top_r;
    bottom_nxt     = bottom_r;
    last_col_nxt   = last_col_r;
    last_valid_nxt = last_valid_r;
    stopped_nxt    = stopped_r;
    emit           = 1'b0;
    if (step_en) begin
      if (stop_now) begin
        stopped_nxt = 1'b1;
      end else begin
        if (extent.any) begin
          if (!open_r) begin
            open_nxt   = 1'b1;
            left_nxt   = col_r;
            top_nxt    = extent.lo;
            bottom_nxt = extent.hi;
          end else begin
            if (extent.lo < top_r) begin
              top_nxt = extent.lo;
            end
            if (extent.hi > bottom_r) begin
              bottom_nxt = extent.hi;
            end
          end
          right_nxt = col_r;
        end else if (open_r) begin
          emit           = 1'b1;
          last_col_nxt   = col_r;
          last_valid_nxt = 1'b1;
          open_nxt       = 1'b0;
          top_nxt        = TOP_RESET;
          bottom_nxt     = '0;
        end
        // image full: drop any open run
        if (col_r == LAST_COL) begin
          stopped_nxt = 1'b1;
          open_nxt    = 1'b0;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      // end of image clears the scan
      if (end_of_image) begin
        col_nxt        = '0;
        open_nxt       = 1'b0;
        left_nxt       = '0;
        right_nxt      = '0;
        top_nxt        = TOP_RESET;
        bottom_nxt     = '0;
        last_col_nxt   = '0;
        last_valid_nxt = 1'b0;
        stopped_nxt    = 1'b0;
      end
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      open_r       <= 1'b0;
      left_r       <= '0;
      right_r      <= '0;
      top_r        <= TOP_RESET;
      bottom_r     <= '0;
      last_col_r   <= '0;
      last_valid_r <= 1'b0;
      stopped_r    <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      open_r       <= open_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      top_r        <= top_nxt;
      bottom_r     <= bottom_nxt;
      last_col_r   <= last_col_nxt;
      last_valid_r <= last_valid_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

  // whitespace size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WS_RESET;
    end else if (cfg_wr_en) begin
      ws_r <= cfg_wr_data;
    end
  end

endmodule

`default_nettype wire

/* design/cpgb_checker.sv */
`default_nettype none
`include "column_projection_glyph_boxer_macros.svh"

module cpgb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  logic [6:0]  row_end;
  logic [11:0] col_end;

  // one past the last row and column of the box
  assign row_end = {2'b00, out_tdata[14:10]} + {1'b0, out_tdata[31:26]};
  assign col_end = {2'b00, out_tdata[9:0]} + {1'b0, out_tdata[25:15]};

  // a waiting box is held until taken
  `CPGB_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a ready sink never stalls the input
  `CPGB_ASSERT_IMP(a_in_ready, out_tready, in_tready)

  // box rows stay inside the column height
  `CPGB_ASSERT_IMP(a_rows, out_tvalid, (out_tdata[31:26] != 6'd0) && (row_end <= 7'd32))

  // box columns stay inside the image
  `CPGB_ASSERT_IMP(a_cols, out_tvalid, (out_tdata[25:15] != 11'd0) && (col_end <= 12'd1024))

endmodule

bind column_projection_glyph_boxer cpgb_checker u_cpgb_checker (.*);

`default_nettype wire
